// File: rtl/shannon_code_builder_top_assert.svh
// Assertion macros shared by the Shannon code builder RTL.
`ifndef SHANNON_CODE_BUILDER_TOP_ASSERT_SVH
`define SHANNON_CODE_BUILDER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked property, switched off while reset is asserted.
`define SCB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define SCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCB_ASSERT(lbl, clk, rstn, prop, msg)
`define SCB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/scb_pkg.sv
// Package with constants, types and the control store of the Shannon code builder.
package scb_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF    = 64;
  localparam int unsigned PROB_FRAC_BITS_DEF = 16;

  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SUM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_COUNT = 2'd3;

  localparam int unsigned STEP_W = 3;

  // Program steps of the sequencer.
  typedef enum logic [STEP_W-1:0] {
    ST_LOAD, ST_CHECK, ST_SINIT, ST_RD, ST_CMP, ST_EMIT, ST_END, ST_ERR
  } step_e;

  // What a step waits for before it advances.
  typedef enum logic [1:0] {
    W_NONE, W_LAST, W_OUT
  } wait_e;

  // Jump conditions, tested once the step advances.
  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_ERROR, C_MORE, C_MORE_OUT
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  scan_init;
    logic  cmp;
    logic  emit_ok;
    logic  emit_err;
    logic  clear;
    wait_e wt;
    cond_e cond;
    step_e target;
  } ucode_t;

  // Control store: one control word per step.
  function automatic ucode_t ucode_rom(input step_e pc);
    ucode_t uc;
    uc = '0;
    uc.wt     = W_NONE;
    uc.cond   = C_NEVER;
    uc.target = ST_LOAD;
    unique case (pc)
      ST_LOAD: begin
        uc.in_ready = 1'b1;
        uc.wt       = W_LAST;
      end
      ST_CHECK: begin
        uc.cond   = C_ERROR;
        uc.target = ST_ERR;
      end
      ST_SINIT: begin
        uc.scan_init = 1'b1;
      end
      ST_RD: begin
        uc.cond = C_NEVER;
      end
      ST_CMP: begin
        uc.cmp    = 1'b1;
        uc.cond   = C_MORE;
        uc.target = ST_RD;
      end
      ST_EMIT: begin
        uc.wt      = W_OUT;
        uc.emit_ok = 1'b1;
        uc.cond    = C_MORE_OUT;
        uc.target  = ST_SINIT;
      end
      ST_END: begin
        uc.clear  = 1'b1;
        uc.cond   = C_ALWAYS;
        uc.target = ST_LOAD;
      end
      ST_ERR: begin
        uc.wt       = W_OUT;
        uc.emit_err = 1'b1;
        uc.clear    = 1'b1;
        uc.cond     = C_ALWAYS;
        uc.target   = ST_LOAD;
      end
    endcase
    return uc;
  endfunction

endpackage

// File: rtl/scb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module scb_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/shannon_code_builder_top.sv
// Top level of the Shannon code builder: loader, microcoded sequencer and output register.

// The block takes a set of symbol probabilities (unsigned fixed point with
// PROB_FRAC_BITS fraction bits, so 1 << PROB_FRAC_BITS means one) as beats on
// the slave stream, tlast marking the final probability of the set. Loading
// runs at one beat per cycle. After the last beat the set is checked: the
// probabilities must sum to exactly one, none may be zero and there may be at
// most MAX_SYMBOLS of them. A failed check gives a single error beat (status
// 3 too many symbols, else 2 zero probability, else 1 sum not one). A good
// set of n symbols gives n beats in descending order of probability, each
// carrying the probability, its Shannon code length and its codeword (the top
// code_length bits of the exclusive cumulative sum). For each beat a selection
// pass reads every stored probability once through the single read port of
// the symbol RAM, two steps of the program per entry, to pick the largest
// remaining one, which is then zeroed in the RAM as the beat is registered;
// the beat waits while the master side stalls. A step that clears the set
// directly follows the step that registers the final good result. The slave
// side is closed from the last beat of a set until its program ends, which
// is right after the error beat is registered or after that clearing step;
// the next set may load while the last result still waits on the master side.
`include "shannon_code_builder_top_assert.svh"

module shannon_code_builder_top #(
  parameter int unsigned MAX_SYMBOLS    = scb_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned PROB_FRAC_BITS = scb_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Slave stream: probabilities.
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // tdata: probability [PROB_FRAC_BITS:0], zero padding above.
  input  logic [((PROB_FRAC_BITS+8)/8)*8-1:0]        s_axis_tdata_i,
  input  logic                                       s_axis_tlast_i,
  // Master stream: code table entries.
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // tdata: sorted_probability, code_length, codeword, zero padding above.
  output logic [((2*PROB_FRAC_BITS+1+$clog2(PROB_FRAC_BITS+1)+7)/8)*8-1:0]
                                                     m_axis_tdata_o,
  // tuser: status.
  output logic [scb_pkg::STATUS_W-1:0]               m_axis_tuser_o,
  output logic                                       m_axis_tlast_o
);

  import scb_pkg::*;

  localparam int unsigned PW     = PROB_FRAC_BITS + 1;
  localparam int unsigned LW     = $clog2(PROB_FRAC_BITS + 1);
  localparam int unsigned AW     = $clog2(MAX_SYMBOLS);
  localparam int unsigned CW     = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned TW     = PW + AW;
  localparam int unsigned OUT_FW = PW + LW + PROB_FRAC_BITS;

  localparam logic [TW-1:0] ONE = TW'(1) << PROB_FRAC_BITS;

  // Sequencer and set state.
  step_e              pc_q, pc_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [TW-1:0]      total_q, total_d;
  logic [STATUS_W-1:0] err_q, err_d;
  logic [PW-1:0]      cum_q, cum_d;
  logic [CW-1:0]      k_q, k_d;
  logic               m_valid_q, m_valid_d;

  // Scan and output payload.
  logic [AW-1:0]       idx_q;
  logic [PW-1:0]       best_val_q;
  logic [AW-1:0]       best_idx_q;
  logic [PW-1:0]       out_prob_q;
  logic [LW-1:0]       out_len_q;
  logic [PW-2:0]       out_cw_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  ucode_t             uc;
  logic               in_fire;
  logic               out_free;
  logic               go;
  logic               cond_true;
  logic               room;
  logic [PW-1:0]      in_prob;
  logic               set_bad;
  logic               scan_more;
  logic               emit_last;
  logic [STATUS_W-1:0] err_status;
  logic [LW-1:0]      msb;
  logic [LW-1:0]      code_len;
  logic [PW-1:0]      cum_shift;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PW-1:0]      ram_wdata;
  logic [PW-1:0]      ram_rdata;

  assign uc       = ucode_rom(pc_q);
  assign in_prob  = s_axis_tdata_i[PW-1:0];
  assign in_fire  = s_axis_tvalid_i && uc.in_ready;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign room     = cnt_q < CW'(MAX_SYMBOLS);

  assign set_bad    = (err_q != STATUS_OK) || (total_q != ONE);
  assign err_status = (err_q != STATUS_OK) ? err_q : STATUS_SUM;
  assign scan_more  = (CW'(idx_q) + CW'(1)) < cnt_q;
  assign emit_last  = (k_q + CW'(1)) == cnt_q;

  // Index of the leading one of the selected probability. The code length is
  // the fraction width minus that index, and the codeword is the cumulative
  // sum shifted right by the same index.
  always_comb begin
    msb = '0;
    for (int i = 0; i < PW; i++) begin
      if (best_val_q[i]) begin
        msb = LW'(i);
      end
    end
  end

  assign code_len  = (msb < LW'(PROB_FRAC_BITS)) ? LW'(PROB_FRAC_BITS) - msb : '0;
  assign cum_shift = cum_q >> msb;

  always_comb begin
    unique case (uc.wt)
      W_NONE: go = 1'b1;
      W_LAST: go = in_fire && s_axis_tlast_i;
      W_OUT:  go = out_free;
      default: go = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uc.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_ERROR:    cond_true = set_bad;
      C_MORE:     cond_true = scan_more;
      C_MORE_OUT: cond_true = !emit_last;
      default:    cond_true = 1'b0;
    endcase
  end

  // Symbol RAM: written while loading, and zeroed at the selected entry on
  // each emitted result so that the next pass skips it.
  assign ram_we    = (in_fire && room) || (uc.emit_ok && go);
  assign ram_waddr = uc.emit_ok ? best_idx_q : cnt_q[AW-1:0];
  assign ram_wdata = uc.emit_ok ? '0 : in_prob;

  scb_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_SYMBOLS)
  ) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pc_d      = pc_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    err_d     = err_q;
    cum_d     = cum_q;
    k_d       = k_q;
    m_valid_d = m_valid_q;

    if (go) begin
      pc_d = cond_true ? uc.target : step_e'(pc_q + STEP_W'(1));
    end

    if (in_fire) begin
      total_d = total_q + TW'(in_prob);
      if ((in_prob == '0) && (err_q < STATUS_ZERO)) begin
        err_d = STATUS_ZERO;
      end
      if (room) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        err_d = STATUS_COUNT;
      end
    end

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    if (uc.emit_ok && go) begin
      cum_d     = cum_q + best_val_q;
      k_d       = k_q + CW'(1);
      m_valid_d = 1'b1;
    end

    if (uc.emit_err && go) begin
      m_valid_d = 1'b1;
    end

    if (uc.clear && go) begin
      cnt_d   = '0;
      total_d = '0;
      err_d   = STATUS_OK;
      cum_d   = '0;
      k_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= ST_LOAD;
      cnt_q     <= '0;
      total_q   <= '0;
      err_q     <= STATUS_OK;
      cum_q     <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      cnt_q     <= cnt_d;
      total_q   <= total_d;
      err_q     <= err_d;
      cum_q     <= cum_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Scan registers and output payload.
  always_ff @(posedge clk_i) begin
    if (uc.scan_init) begin
      idx_q      <= '0;
      best_val_q <= '0;
      best_idx_q <= '0;
    end
    if (uc.cmp) begin
      if (ram_rdata > best_val_q) begin
        best_val_q <= ram_rdata;
        best_idx_q <= idx_q;
      end
      idx_q <= idx_q + AW'(1);
    end
    if (uc.emit_ok && go) begin
      out_prob_q   <= best_val_q;
      out_len_q    <= code_len;
      out_cw_q     <= cum_shift[PW-2:0];
      out_status_q <= STATUS_OK;
      out_last_q   <= emit_last;
    end
    if (uc.emit_err && go) begin
      out_prob_q   <= '0;
      out_len_q    <= '0;
      out_cw_q     <= '0;
      out_status_q <= err_status;
      out_last_q   <= 1'b1;
    end
  end

  assign s_axis_tready_o = uc.in_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    m_axis_tdata_o                           = '0;
    m_axis_tdata_o[PW-1:0]                   = out_prob_q;
    m_axis_tdata_o[PW+LW-1:PW]               = out_len_q;
    m_axis_tdata_o[OUT_FW-1:PW+LW]           = out_cw_q;
  end

  `SCB_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(MAX_SYMBOLS), "symbol count beyond capacity")
  `SCB_ASSERT(a_emit_count, clk_i, rst_ni, k_q <= cnt_q, "more results than stored symbols")
  `SCB_ASSERT(a_sel_index, clk_i, rst_ni, (pc_q == ST_EMIT) |-> (CW'(best_idx_q) < cnt_q), "selected entry outside the set")
  `SCB_ASSERT(a_ok_nonzero, clk_i, rst_ni, (m_valid_q && (out_status_q == STATUS_OK)) |-> (out_prob_q != '0), "good result with zero probability")
  `SCB_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule
